### rtl/dmxut_pkg.sv
// ----------------------------------------------------------------------------
// DMX512 universe transmitter package
// Shared item, result and code definitions for the transmitter block.
// ----------------------------------------------------------------------------
package dmxut_pkg;

  // Frame length, send index and range pointers cover 0..512.
  localparam int LEN_W = 10;
  localparam int CFG_IDX_W = 4;

  typedef logic [LEN_W-1:0] len_t;

  // Item kinds
  typedef enum logic [2:0] {
    KIND_MIDI   = 3'd0,
    KIND_SET    = 3'd1,
    KIND_HEADER = 3'd2,
    KIND_BYTE   = 3'd3,
    KIND_TICK   = 3'd4
  } kind_t;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BREAK_TICKS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_MAB_TICKS   = CFG_IDX_W'(1);

  localparam logic [7:0] BREAK_TICKS_RESET = 8'd133;
  localparam logic [7:0] MAB_TICKS_RESET   = 8'd13;

  // MIDI status bytes
  localparam logic [7:0] MIDI_CC       = 8'hB0;
  localparam logic [7:0] MIDI_NOTE_ON  = 8'h90;
  localparam logic [7:0] MIDI_NOTE_OFF = 8'h80;
  localparam logic [7:0] MIDI_CC_LIMIT = 8'd120;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_BAD_CHANNEL = 2'd1,
    ST_BAD_VALUE   = 2'd2,
    ST_REFUSED     = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_NONE = 2'd0,
    ACT_SEND = 2'd1,
    ACT_LOW  = 2'd2,
    ACT_HIGH = 2'd3
  } action_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  midi_status;
    logic [7:0]  midi_number;
    logic [7:0]  midi_level;
    logic [15:0] channel;
    logic [15:0] value_word;
    logic [15:0] range_count;
    logic [15:0] range_limit;
    logic [7:0]  data_byte;
    logic        uart_empty;
    logic        uart_idle;
  } item_t;

  // Result of one item; from_store selects the store read data as tx_byte.
  typedef struct packed {
    status_t    status;
    logic       range_done;
    action_t    line_action;
    logic [7:0] tx_byte;
    logic       from_store;
  } res_t;

endpackage

### rtl/dmxut_if.sv
// ----------------------------------------------------------------------------
// DMX512 universe transmitter channel interfaces
// Item, result and configuration write channels with valid/ready handshake.
// ----------------------------------------------------------------------------
interface dmxut_item_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [7:0]  midi_status;
  logic [7:0]  midi_number;
  logic [7:0]  midi_level;
  logic [15:0] channel;
  logic [15:0] value_word;
  logic [15:0] range_count;
  logic [15:0] range_limit;
  logic [7:0]  data_byte;
  logic        uart_empty;
  logic        uart_idle;

  modport source (
    output valid, kind, midi_status, midi_number, midi_level, channel,
           value_word, range_count, range_limit, data_byte, uart_empty,
           uart_idle,
    input  ready
  );
  modport sink (
    input  valid, kind, midi_status, midi_number, midi_level, channel,
           value_word, range_count, range_limit, data_byte, uart_empty,
           uart_idle,
    output ready
  );
endinterface

interface dmxut_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic       range_done;
  logic [1:0] line_action;
  logic [7:0] tx_byte;

  modport source (
    output valid, status, range_done, line_action, tx_byte,
    input  ready
  );
  modport sink (
    input  valid, status, range_done, line_action, tx_byte,
    output ready
  );
endinterface

interface dmxut_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [dmxut_pkg::CFG_IDX_W-1:0]  index;
  logic [7:0]                       data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### rtl/dmxut_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with enable and registered read data.
// ----------------------------------------------------------------------------
module dmxut_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 512,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/dmxut_ctrl.sv
// ----------------------------------------------------------------------------
// DMX512 universe transmitter control
// Decodes writes, tracks frame length and range state, runs the frame sequence.
// ----------------------------------------------------------------------------
module dmxut_ctrl #(
  parameter int CHANNELS = 512,
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            accept,
  input  dmxut_pkg::item_t                item,
  input  logic                            cfg_we,
  input  logic [dmxut_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  output dmxut_pkg::res_t                 res,
  output logic                            wr_en,
  output logic [AW-1:0]                   wr_addr,
  output logic [7:0]                      wr_data,
  output logic                            rd_en,
  output logic [AW-1:0]                   rd_addr
);

  typedef enum logic [2:0] {
    PH_OFF   = 3'd0,
    PH_NEW   = 3'd1,
    PH_DATA  = 3'd2,
    PH_END   = 3'd3,
    PH_BREAK = 3'd4,
    PH_MAB   = 3'd5
  } phase_t;

  localparam logic [16:0] CH_LIM = 17'(CHANNELS);

  phase_t            phase, phase_next;
  dmxut_pkg::len_t   frame_length, frame_length_next;
  dmxut_pkg::len_t   send_index, send_index_next;
  logic              range_active, range_active_next;
  dmxut_pkg::len_t   range_pos, range_pos_next;
  dmxut_pkg::len_t   range_end, range_end_next;
  logic [7:0]        gap_count, gap_count_next;
  logic [7:0]        break_ticks, mab_ticks;

  logic              grow_en, start_en;
  dmxut_pkg::len_t   grow_len;
  logic              num_ok;
  logic [16:0]       hdr_end;
  logic              pos_room;
  dmxut_pkg::len_t   pos_inc;

  assign num_ok   = {9'd0, item.midi_number} < CH_LIM;
  assign hdr_end  = {1'b0, item.channel} + {1'b0, item.range_count};
  assign pos_room = range_pos < range_end;
  assign pos_inc  = pos_room ? range_pos + dmxut_pkg::len_t'(1) : range_pos;
  assign rd_addr  = send_index[AW-1:0];

  always_comb begin
    phase_next        = phase;
    frame_length_next = frame_length;
    send_index_next   = send_index;
    range_active_next = range_active;
    range_pos_next    = range_pos;
    range_end_next    = range_end;
    gap_count_next    = gap_count;
    grow_en           = 1'b0;
    grow_len          = '0;
    start_en          = 1'b0;
    res               = '0;
    wr_en             = 1'b0;
    wr_addr           = '0;
    wr_data           = '0;
    rd_en             = 1'b0;

    case (dmxut_pkg::kind_t'(item.kind))
      dmxut_pkg::KIND_MIDI: begin
        wr_addr  = AW'(item.midi_number);
        wr_data  = {item.midi_level[6:0], 1'b0};
        grow_len = dmxut_pkg::len_t'(item.midi_number) + dmxut_pkg::len_t'(1);
        if (item.midi_status == dmxut_pkg::MIDI_CC) begin
          if (num_ok && item.midi_number < dmxut_pkg::MIDI_CC_LIMIT) begin
            wr_en   = 1'b1;
            grow_en = 1'b1;
          end
          start_en = 1'b1;
        end else if (item.midi_status == dmxut_pkg::MIDI_NOTE_ON) begin
          wr_en    = num_ok;
          grow_en  = num_ok;
          start_en = 1'b1;
        end else if (item.midi_status == dmxut_pkg::MIDI_NOTE_OFF) begin
          wr_en   = num_ok;
          wr_data = '0;
        end
      end
      dmxut_pkg::KIND_SET: begin
        wr_addr  = item.channel[AW-1:0];
        wr_data  = item.value_word[7:0];
        grow_len = item.channel[dmxut_pkg::LEN_W-1:0] + dmxut_pkg::len_t'(1);
        if ({1'b0, item.channel} > CH_LIM - 17'd1) begin
          res.status = dmxut_pkg::ST_BAD_CHANNEL;
        end else if (item.value_word[15:8] != 8'd0) begin
          res.status = dmxut_pkg::ST_BAD_VALUE;
        end else begin
          wr_en    = 1'b1;
          grow_en  = 1'b1;
          start_en = 1'b1;
        end
      end
      dmxut_pkg::KIND_HEADER: begin
        if (item.range_count > item.range_limit) begin
          res.status     = dmxut_pkg::ST_BAD_VALUE;
          range_pos_next = '0;
          range_end_next = '0;
        end else if ({1'b0, item.channel} > CH_LIM - 17'd1 || hdr_end > CH_LIM) begin
          res.status     = dmxut_pkg::ST_BAD_CHANNEL;
          range_pos_next = '0;
          range_end_next = '0;
        end else begin
          range_active_next = 1'b1;
          range_pos_next    = item.channel[dmxut_pkg::LEN_W-1:0];
          range_end_next    = hdr_end[dmxut_pkg::LEN_W-1:0];
        end
      end
      dmxut_pkg::KIND_BYTE: begin
        if (!range_active) begin
          res.status = dmxut_pkg::ST_REFUSED;
        end else begin
          wr_en          = pos_room;
          wr_addr        = range_pos[AW-1:0];
          wr_data        = item.data_byte;
          range_pos_next = pos_inc;
          grow_en        = 1'b1;
          grow_len       = pos_inc;
          start_en       = 1'b1;
          if (pos_inc >= range_end) begin
            range_active_next = 1'b0;
            res.range_done    = 1'b1;
          end
        end
      end
      dmxut_pkg::KIND_TICK: begin
        if (frame_length != '0) begin
          unique case (phase)
            PH_NEW: begin
              send_index_next = '0;
              res.line_action = dmxut_pkg::ACT_SEND;
              phase_next      = PH_DATA;
            end
            PH_DATA: begin
              if (item.uart_empty) begin
                if (send_index < frame_length) begin
                  res.line_action = dmxut_pkg::ACT_SEND;
                  res.from_store  = 1'b1;
                  rd_en           = 1'b1;
                  send_index_next = send_index + dmxut_pkg::len_t'(1);
                end else if (item.uart_idle) begin
                  res.line_action = dmxut_pkg::ACT_LOW;
                  gap_count_next  = break_ticks;
                  phase_next      = PH_BREAK;
                end else begin
                  phase_next = PH_END;
                end
              end
            end
            PH_END: begin
              if (item.uart_idle) begin
                res.line_action = dmxut_pkg::ACT_LOW;
                gap_count_next  = break_ticks;
                phase_next      = PH_BREAK;
              end
            end
            PH_BREAK: begin
              if (gap_count <= 8'd1) begin
                res.line_action = dmxut_pkg::ACT_HIGH;
                gap_count_next  = mab_ticks;
                phase_next      = PH_MAB;
              end else begin
                gap_count_next = gap_count - 8'd1;
              end
            end
            PH_MAB: begin
              if (gap_count <= 8'd1) begin
                gap_count_next = '0;
                phase_next     = PH_NEW;
              end else begin
                gap_count_next = gap_count - 8'd1;
              end
            end
            default: begin
            end
          endcase
        end
      end
      default: begin
      end
    endcase

    if (grow_en && grow_len > frame_length) begin
      frame_length_next = grow_len;
    end
    if (start_en && phase == PH_OFF) begin
      phase_next = PH_NEW;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_OFF;
      frame_length <= '0;
      send_index   <= '0;
      range_active <= 1'b0;
      range_pos    <= '0;
      range_end    <= '0;
      gap_count    <= '0;
      break_ticks  <= dmxut_pkg::BREAK_TICKS_RESET;
      mab_ticks    <= dmxut_pkg::MAB_TICKS_RESET;
    end else begin
      if (accept) begin
        phase        <= phase_next;
        frame_length <= frame_length_next;
        send_index   <= send_index_next;
        range_active <= range_active_next;
        range_pos    <= range_pos_next;
        range_end    <= range_end_next;
        gap_count    <= gap_count_next;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          dmxut_pkg::REG_BREAK_TICKS: break_ticks <= cfg_data;
          dmxut_pkg::REG_MAB_TICKS:   mab_ticks   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

endmodule

### rtl/dmxut_top_pipe.sv
// ----------------------------------------------------------------------------
// DMX512 universe transmitter result pipeline
// Joins the store read data to the decoded result and holds it for the sink.
// ----------------------------------------------------------------------------
module dmxut_top_pipe (
  input  logic            clk,
  input  logic            rst,
  input  logic            accept,
  input  dmxut_pkg::res_t res_in,
  input  logic [7:0]      store_q,
  output logic            take_ok,
  output logic            out_valid,
  input  logic            out_ready,
  output dmxut_pkg::res_t out_res
);

  logic            p1_valid;
  dmxut_pkg::res_t p1_res;
  dmxut_pkg::res_t p1_final;
  logic            p1_move;

  assign p1_move = !out_valid || out_ready;
  assign take_ok = !p1_valid || p1_move;

  always_comb begin
    p1_final = p1_res;
    if (p1_res.from_store) begin
      p1_final.tx_byte = store_q;
    end
    p1_final.from_store = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (take_ok) begin
        p1_valid <= accept;
      end
      if (p1_move) begin
        out_valid <= p1_valid;
      end
    end
    // Payload: load on move, hold otherwise.
    if (accept) begin
      p1_res <= res_in;
    end
    if (p1_move && p1_valid) begin
      out_res <= p1_final;
    end
  end

endmodule

### rtl/dmx512_universe_transmitter_top.sv
// ----------------------------------------------------------------------------
// DMX512 universe transmitter
// Channel store, write decoding and frame sequencing for one DMX universe.
// ----------------------------------------------------------------------------
// Takes one item per clock cycle, writes and ticks alike, while the sink
// keeps up, and returns exactly one result per item through two registers:
// the first reads the channel store (registered read) and holds the decoded
// result, the second holds the finished result for the sink. While the sink
// stalls, those two registers take at most one more item; once both hold
// results, items.ready follows results.ready in the same cycle. After reset
// the block clears the channel store, one entry per cycle, with items.ready low;
// configuration writes are taken at any time, cfg.ready is always high.
// ----------------------------------------------------------------------------
module dmx512_universe_transmitter_top #(
  parameter int CHANNELS = 512
) (
  input  logic              clk,
  input  logic              rst,
  dmxut_item_if.sink        items,
  dmxut_result_if.source    results,
  dmxut_cfg_if.sink         cfg
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [AW-1:0] LAST_ADDR = AW'(CHANNELS - 1);

  dmxut_pkg::item_t item;
  dmxut_pkg::res_t  ctrl_res;
  dmxut_pkg::res_t  out_res;
  logic             accept;
  logic             take_ok;

  // Store-clearing sweep after reset
  logic             clr_busy;
  logic [AW-1:0]    clr_addr;

  logic             ctrl_we, ctrl_re;
  logic [AW-1:0]    ctrl_waddr, ctrl_raddr;
  logic [7:0]       ctrl_wdata;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  logic [7:0]       ram_wdata;
  logic [7:0]       store_q;

  // Gather the item fields for the decoder.
  assign item.kind        = items.kind;
  assign item.midi_status = items.midi_status;
  assign item.midi_number = items.midi_number;
  assign item.midi_level  = items.midi_level;
  assign item.channel     = items.channel;
  assign item.value_word  = items.value_word;
  assign item.range_count = items.range_count;
  assign item.range_limit = items.range_limit;
  assign item.data_byte   = items.data_byte;
  assign item.uart_empty  = items.uart_empty;
  assign item.uart_idle   = items.uart_idle;

  // Hold off items during the sweep and while the result stages are full.
  assign items.ready = !clr_busy && take_ok;
  assign accept      = items.valid && items.ready;
  assign cfg.ready   = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == LAST_ADDR) begin
        clr_busy <= 1'b0;
      end
    end
  end

  dmxut_ctrl #(
    .CHANNELS (CHANNELS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .item      (item),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_index (cfg.index),
    .cfg_data  (cfg.data),
    .res       (ctrl_res),
    .wr_en     (ctrl_we),
    .wr_addr   (ctrl_waddr),
    .wr_data   (ctrl_wdata),
    .rd_en     (ctrl_re),
    .rd_addr   (ctrl_raddr)
  );

  // The sweep owns the write port until it finishes; no item is taken then.
  assign ram_we    = clr_busy || (accept && ctrl_we);
  assign ram_waddr = clr_busy ? clr_addr : ctrl_waddr;
  assign ram_wdata = clr_busy ? 8'd0 : ctrl_wdata;

  dmxut_ram #(
    .WIDTH (8),
    .DEPTH (CHANNELS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (accept && ctrl_re),
    .raddr (ctrl_raddr),
    .rdata (store_q)
  );

  dmxut_top_pipe u_pipe (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .res_in    (ctrl_res),
    .store_q   (store_q),
    .take_ok   (take_ok),
    .out_valid (results.valid),
    .out_ready (results.ready),
    .out_res   (out_res)
  );

  // Drive the result payload from the output register.
  assign results.status      = out_res.status;
  assign results.range_done  = out_res.range_done;
  assign results.line_action = out_res.line_action;
  assign results.tx_byte     = out_res.tx_byte;

endmodule
